// ===== sv/iqr_pkg.sv =====
// Shared types and constants for the quarter-turn frame rotator.
// Used by iqr_ctrl, iqr_datapath and image_quarter_turn_rotator_core.
package iqr_pkg;

  localparam int unsigned PIXEL_BITS  = 24;
  localparam int unsigned POS_BITS    = 6;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_DIM_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_R90  = 2'd1;
  localparam logic [1:0] MODE_R180 = 2'd2;
  localparam logic [1:0] MODE_R270 = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic                  op;
    logic [PIXEL_BITS-1:0] pixel_in;
  } in_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic [POS_BITS-1:0]   out_row;
    logic [POS_BITS-1:0]   out_col;
    logic                  frame_last;
  } out_t;

  typedef struct packed {
    logic load;
    logic fetch;
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

// ===== sv/iqr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module iqr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/iqr_ctrl.sv =====
// Controller for the frame rotator: accepts commands and sequences result strobes.
// Depends on iqr_pkg.
module iqr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           op_i,
  output logic           busy,
  output iqr_pkg::ctrl_t cmd_o,
  output logic           done_o
);

  iqr_pkg::state_e state_q, state_d;
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cmd_o.load  = accept && (op_i == iqr_pkg::OP_WRITE);
    cmd_o.fetch = accept && (op_i == iqr_pkg::OP_READ);
  end

  always_comb begin
    unique case (state_q)
      iqr_pkg::ST_IDLE: state_d = cmd_o.fetch ? iqr_pkg::ST_EMIT : iqr_pkg::ST_IDLE;
      iqr_pkg::ST_EMIT: state_d = cmd_o.fetch ? iqr_pkg::ST_EMIT : iqr_pkg::ST_IDLE;
      default:          state_d = iqr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iqr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign done_o = (state_q == iqr_pkg::ST_EMIT);

endmodule

// ===== sv/iqr_datapath.sv =====
// Datapath for the frame rotator: config registers, raster counters, address generation, frame store.
// Depends on iqr_pkg and iqr_ram.
module iqr_datapath #(
  parameter int unsigned MAX_DIM = iqr_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iqr_pkg::ctrl_t                cmd_i,
  input  logic [iqr_pkg::PIXEL_BITS-1:0] pixel_i,
  input  logic                          cfg_we_i,
  input  logic [iqr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [iqr_pkg::CFG_W-1:0]     cfg_data_i,
  output iqr_pkg::out_t                 out_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned EXT_W  = (DIM_W > iqr_pkg::CFG_W) ? DIM_W : iqr_pkg::CFG_W;
  localparam int unsigned ADDR_W = 2 * CNT_W;

  logic [1:0]                mode_q;
  logic [iqr_pkg::CFG_W-1:0] width_q, height_q;

  logic [CNT_W-1:0] load_row_q, load_row_d, load_col_q, load_col_d;
  logic [CNT_W-1:0] emit_row_q, emit_row_d, emit_col_q, emit_col_d;
  logic [CNT_W-1:0] res_row_q, res_col_q;
  logic             res_last_q;

  logic [DIM_W-1:0] dim_w, dim_h, orows, ocols;
  logic [CNT_W-1:0] lr, lc, er, ec;
  logic [DIM_W-1:0] lc_inc, lr_inc, ec_inc, er_inc;
  logic [DIM_W-1:0] sr, sc;
  logic             last;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [iqr_pkg::PIXEL_BITS-1:0] rdata;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [iqr_pkg::CFG_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext == '0) begin
      return DIM_W'(1);
    end else if (ext > EXT_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return ext[DIM_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= iqr_pkg::MODE_NONE;
      width_q  <= iqr_pkg::DIM_RESET;
      height_q <= iqr_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iqr_pkg::REG_MODE:   mode_q   <= cfg_data_i[1:0];
        iqr_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        iqr_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dim_w = clamp_dim(width_q);
  assign dim_h = clamp_dim(height_q);
  assign orows = mode_q[0] ? dim_w : dim_h;
  assign ocols = mode_q[0] ? dim_h : dim_w;

  // Write side: restart when outside the frame, then advance in source raster order.
  always_comb begin
    if (DIM_W'(load_row_q) >= dim_h || DIM_W'(load_col_q) >= dim_w) begin
      lr = '0;
      lc = '0;
    end else begin
      lr = load_row_q;
      lc = load_col_q;
    end
    lc_inc = DIM_W'(lc) + DIM_W'(1);
    lr_inc = DIM_W'(lr) + DIM_W'(1);
    if (lc_inc < dim_w) begin
      load_col_d = lc_inc[CNT_W-1:0];
      load_row_d = lr;
    end else begin
      load_col_d = '0;
      load_row_d = (lr_inc < dim_h) ? lr_inc[CNT_W-1:0] : '0;
    end
  end

  // Read side: restart when outside the rotated frame, map to source, advance.
  always_comb begin
    if (DIM_W'(emit_row_q) >= orows || DIM_W'(emit_col_q) >= ocols) begin
      er = '0;
      ec = '0;
    end else begin
      er = emit_row_q;
      ec = emit_col_q;
    end
    case (mode_q)
      iqr_pkg::MODE_R90: begin
        sr = dim_h - DIM_W'(1) - DIM_W'(ec);
        sc = DIM_W'(er);
      end
      iqr_pkg::MODE_R180: begin
        sr = dim_h - DIM_W'(1) - DIM_W'(er);
        sc = dim_w - DIM_W'(1) - DIM_W'(ec);
      end
      iqr_pkg::MODE_R270: begin
        sr = DIM_W'(ec);
        sc = dim_w - DIM_W'(1) - DIM_W'(er);
      end
      default: begin
        sr = DIM_W'(er);
        sc = DIM_W'(ec);
      end
    endcase
    ec_inc = DIM_W'(ec) + DIM_W'(1);
    er_inc = DIM_W'(er) + DIM_W'(1);
    last   = (er_inc == orows) && (ec_inc == ocols);
    if (ec_inc < ocols) begin
      emit_col_d = ec_inc[CNT_W-1:0];
      emit_row_d = er;
    end else begin
      emit_col_d = '0;
      emit_row_d = (er_inc < orows) ? er_inc[CNT_W-1:0] : '0;
    end
  end

  assign waddr = {lr, lc};
  assign raddr = {sr[CNT_W-1:0], sc[CNT_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q <= '0;
      load_col_q <= '0;
      emit_row_q <= '0;
      emit_col_q <= '0;
    end else begin
      if (cmd_i.load) begin
        load_row_q <= load_row_d;
        load_col_q <= load_col_d;
      end
      if (cmd_i.fetch) begin
        emit_row_q <= emit_row_d;
        emit_col_q <= emit_col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      res_row_q  <= er;
      res_col_q  <= ec;
      res_last_q <= last;
    end
  end

  iqr_ram #(
    .WIDTH (iqr_pkg::PIXEL_BITS),
    .DEPTH (2 ** ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (waddr),
    .wdata_i (pixel_i),
    .re_i    (cmd_i.fetch),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    out_o.pixel_out  = rdata;
    out_o.out_row    = iqr_pkg::POS_BITS'(res_row_q);
    out_o.out_col    = iqr_pkg::POS_BITS'(res_col_q);
    out_o.frame_last = res_last_q;
  end

endmodule

// ===== sv/image_quarter_turn_rotator_core.sv =====
// Top level of the quarter-turn frame rotator: controller plus datapath.
// Depends on iqr_pkg, iqr_ctrl, iqr_datapath and iqr_ram.
//
// Usage:
//   Command channel: in_i is taken at a rising edge with start high and busy low.
//   busy stays low, so a command can be issued every cycle.
//   A write command (op = 0) stores pixel_in at the next source raster position.
//   A read command (op = 1) fetches the next pixel of the rotated frame.
//   Result channel: done_o is high for one cycle, in the cycle after the read
//   command, with out_o valid in that cycle; the receiver cannot stall it.
//   Reads pass through the registered frame store read port;
//   throughput is one command per cycle. Writes produce no result.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 mode, 1 width, 2 height); other indexes are ignored.
//   Reset clears both raster positions and loads mode 0, width 64, height 64;
//   the frame store has no reset and must be written before it is read.
module image_quarter_turn_rotator_core #(
  parameter int unsigned MAX_DIM = iqr_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  iqr_pkg::in_t                  in_i,
  output logic                          done_o,
  output iqr_pkg::out_t                 out_o,
  input  logic                          cfg_we_i,
  input  logic [iqr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [iqr_pkg::CFG_W-1:0]     cfg_data_i
);

  iqr_pkg::ctrl_t cmd;

  iqr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (in_i.op),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  iqr_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .pixel_i    (in_i.pixel_in),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_o      (out_o)
  );

endmodule
